>>> hw/rtl/proximity_alarm_controller_macros.svh
// Assertion macros shared by the proximity alarm checker.
`ifndef PROXIMITY_ALARM_CONTROLLER_MACROS_SVH
`define PROXIMITY_ALARM_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PAC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("proximity alarm check failed");

// Next-cycle implication, disabled while reset is high.
`define PAC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("proximity alarm check failed");

`endif

>>> hw/rtl/pac_pkg.sv
// Types and constants of the proximity alarm controller.
package pac_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned DIST_W   = 16;
   localparam int unsigned COLOUR_W = 24;
   localparam int unsigned CSR_W    = 24;
   localparam int unsigned CSR_IDX_W = 3;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] cmd_type;

   localparam mode_type MODE_OFF      = 2'd0;
   localparam mode_type MODE_WATCHING = 2'd1;
   localparam mode_type MODE_ON       = 2'd2;
   localparam mode_type MODE_TESTING  = 2'd3;

   localparam cmd_type CMD_UPDATE   = 2'd0;
   localparam cmd_type CMD_REQ_ON   = 2'd1;
   localparam cmd_type CMD_REQ_OFF  = 2'd2;
   localparam cmd_type CMD_TEST     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WATCH_TMO  = 3'd4;

   localparam logic [COLOUR_W-1:0] COLOUR_A_RST  = 24'hFF0000;
   localparam logic [COLOUR_W-1:0] COLOUR_B_RST  = 24'h0000FF;
   localparam logic [15:0]         BLINK_RST     = 16'd250;
   localparam logic [DIST_W-1:0]   TRIGGER_RST   = 16'd240;
   localparam logic [15:0]         WATCH_TMO_RST = 16'd3000;

   localparam logic [TIME_W-1:0]   TEST_DURATION_MS = 32'd3000;

   // Result word, lowest bits first: mode, red, green, blue, buzzer.
   typedef struct packed {
      logic       buzzer_on;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      mode_type   mode;
   } result_type;

endpackage

>>> hw/rtl/proximity_alarm_controller.sv
// An accepted transfer passes through the input register and then the result register before its result shows.
// Throughput: one item per cycle while results are taken; the mode update is one pass of logic from the input register.
// A result waiting on rsp_tready stalls the input register; once that holds an item, req_tready goes low.
// Reset is synchronous, active high: mode off, pending requests clear, LEDs dark,
// buzzer silent, time marks zero and configuration registers at their defaults.
module proximity_alarm_controller (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // now_ms [31:0], distance [47:32]
   input  logic [1:0]  req_tuser,  // command [1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // mode [1:0], red [9:2], green [17:10],
                                   // blue [25:18], buzzer_on [26], zero [31:27]
);

   // configuration
   logic [pac_pkg::COLOUR_W-1:0] colour_a_ff;
   logic [pac_pkg::COLOUR_W-1:0] colour_b_ff;
   logic [15:0]                  blink_ff;
   logic [pac_pkg::DIST_W-1:0]   trigger_ff;
   logic [15:0]                  watch_tmo_ff;

   // input register
   logic                         in_vld_ff;
   pac_pkg::cmd_type             cmd_ff;
   logic [pac_pkg::TIME_W-1:0]   now_ff;
   logic [pac_pkg::DIST_W-1:0]   dist_ff;

   // alarm state
   pac_pkg::mode_type            mode_ff, mode_in;
   logic                         pend_on_ff, pend_on_in;
   logic                         pend_off_ff, pend_off_in;
   logic                         phase_ff, phase_in;
   logic [pac_pkg::TIME_W-1:0]   seen_ff, seen_in;
   logic [pac_pkg::TIME_W-1:0]   toggle_ff, toggle_in;
   logic [pac_pkg::TIME_W-1:0]   test_ff, test_in;
   logic [pac_pkg::COLOUR_W-1:0] led_ff, led_in;
   logic                         buzz_ff, buzz_in;

   // result register
   logic                         out_vld_ff;
   pac_pkg::result_type          out_ff, out_in;

   logic                         advance;
   logic                         close_hit;
   logic                         blink_due;
   logic                         watch_expired;
   logic                         test_expired;

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = !reset && (!in_vld_ff || advance);

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_ff};

   assign close_hit     = dist_ff <= trigger_ff;
   assign blink_due     = (now_ff - toggle_ff) >= {16'd0, blink_ff};
   assign watch_expired = (now_ff - seen_ff) >= {16'd0, watch_tmo_ff};
   assign test_expired  = (now_ff - test_ff) >= pac_pkg::TEST_DURATION_MS;

   always_comb begin
      logic pend_on_v;
      mode_in     = mode_ff;
      pend_on_in  = pend_on_ff;
      pend_off_in = pend_off_ff;
      phase_in    = phase_ff;
      seen_in     = seen_ff;
      toggle_in   = toggle_ff;
      test_in     = test_ff;
      led_in      = led_ff;
      buzz_in     = buzz_ff;
      pend_on_v   = pend_on_ff;
      case (cmd_ff)
         pac_pkg::CMD_UPDATE: begin
            case (mode_ff)
               pac_pkg::MODE_OFF: begin
                  if (close_hit) begin
                     mode_in = pac_pkg::MODE_WATCHING;
                     seen_in = now_ff;
                  end
               end
               pac_pkg::MODE_WATCHING: begin
                  if (!close_hit) begin
                     if (watch_expired) begin
                        mode_in = pac_pkg::MODE_OFF;
                        led_in  = '0;
                        buzz_in = 1'b0;
                     end
                  end else begin
                     seen_in   = now_ff;
                     mode_in   = pac_pkg::MODE_ON;
                     pend_on_v = 1'b1;
                  end
               end
               pac_pkg::MODE_ON: begin
                  if (!close_hit) begin
                     mode_in = pac_pkg::MODE_WATCHING;
                     seen_in = now_ff;
                  end else if (blink_due) begin
                     toggle_in = now_ff;
                     phase_in  = !phase_ff;
                     led_in    = phase_ff ? colour_a_ff : colour_b_ff;
                  end
               end
               default: begin
                  if (test_expired) begin
                     mode_in = pac_pkg::MODE_OFF;
                     led_in  = '0;
                     buzz_in = 1'b0;
                  end else if (blink_due) begin
                     toggle_in = now_ff;
                     phase_in  = !phase_ff;
                     led_in    = phase_ff ? colour_a_ff : colour_b_ff;
                  end
               end
            endcase
            // apply pending turn-on, then turn-off which wins
            if (pend_on_v) begin
               mode_in   = pac_pkg::MODE_ON;
               buzz_in   = 1'b1;
               toggle_in = now_ff;
               phase_in  = 1'b0;
               led_in    = colour_a_ff;
            end
            pend_on_in = 1'b0;
            if (pend_off_ff) begin
               mode_in = pac_pkg::MODE_OFF;
               led_in  = '0;
               buzz_in = 1'b0;
            end
            pend_off_in = 1'b0;
         end
         pac_pkg::CMD_REQ_ON: begin
            if (mode_ff == pac_pkg::MODE_OFF) begin
               pend_on_in = 1'b1;
            end
         end
         pac_pkg::CMD_REQ_OFF: begin
            if (mode_ff != pac_pkg::MODE_TESTING) begin
               pend_off_in = 1'b1;
            end
         end
         default: begin
            mode_in  = pac_pkg::MODE_TESTING;
            test_in  = now_ff;
            buzz_in  = 1'b1;
            phase_in = 1'b0;
            led_in   = colour_a_ff;
         end
      endcase
   end

   always_comb begin
      out_in.mode      = mode_in;
      out_in.red       = led_in[23:16];
      out_in.green     = led_in[15:8];
      out_in.blue      = led_in[7:0];
      out_in.buzzer_on = buzz_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_a_ff  <= pac_pkg::COLOUR_A_RST;
         colour_b_ff  <= pac_pkg::COLOUR_B_RST;
         blink_ff     <= pac_pkg::BLINK_RST;
         trigger_ff   <= pac_pkg::TRIGGER_RST;
         watch_tmo_ff <= pac_pkg::WATCH_TMO_RST;
      end else if (csr_we) begin
         case (csr_index)
            pac_pkg::REG_COLOUR_A:  colour_a_ff  <= csr_wdata;
            pac_pkg::REG_COLOUR_B:  colour_b_ff  <= csr_wdata;
            pac_pkg::REG_BLINK:     blink_ff     <= csr_wdata[15:0];
            pac_pkg::REG_TRIGGER:   trigger_ff   <= csr_wdata[15:0];
            pac_pkg::REG_WATCH_TMO: watch_tmo_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   // payload of the input register needs no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff  <= req_tuser;
         now_ff  <= req_tdata[31:0];
         dist_ff <= req_tdata[47:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= pac_pkg::MODE_OFF;
         pend_on_ff  <= 1'b0;
         pend_off_ff <= 1'b0;
         phase_ff    <= 1'b0;
         seen_ff     <= '0;
         toggle_ff   <= '0;
         test_ff     <= '0;
         led_ff      <= '0;
         buzz_ff     <= 1'b0;
      end else if (in_vld_ff && advance) begin
         mode_ff     <= mode_in;
         pend_on_ff  <= pend_on_in;
         pend_off_ff <= pend_off_in;
         phase_ff    <= phase_in;
         seen_ff     <= seen_in;
         toggle_ff   <= toggle_in;
         test_ff     <= test_in;
         led_ff      <= led_in;
         buzz_ff     <= buzz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_ff && advance) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> hw/rtl/pac_checker.sv
// Port-level checker of the proximity alarm controller and its bind.
`include "proximity_alarm_controller_macros.svh"

module pac_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // hold a stalled result transfer
   `PAC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // off always shows dark LEDs and a silent buzzer
   `PAC_ASSERT_IMP(a_off_silent, clock, reset, rsp_tvalid && (rsp_tdata[1:0] == pac_pkg::MODE_OFF), rsp_tdata[26:2] == 25'd0)

   // alarm and test modes always sound the buzzer
   `PAC_ASSERT_IMP(a_alarm_buzz, clock, reset, rsp_tvalid && ((rsp_tdata[1:0] == pac_pkg::MODE_ON) || (rsp_tdata[1:0] == pac_pkg::MODE_TESTING)), rsp_tdata[26])

   // no result straight out of reset
   `PAC_ASSERT_IMP(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind proximity_alarm_controller pac_checker u_pac_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
